FILE: rtl/lkv_pkg.sv
// Shared types, constants and handshake structs for the LRU key/value cache.
// No dependencies; the files that use this package refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package lkv_pkg;

  localparam int ENTRIES    = 16;
  localparam int VALUE_BITS = 32;
  localparam int KEY_BITS   = 64;
  localparam int CAP_BITS   = 5;
  localparam int SLOT_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W      = $clog2(ENTRIES + 1);

  typedef logic [SLOT_W-1:0]     slot_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [CAP_BITS-1:0]   cap_t;
  typedef logic [1:0]            cmd_t;
  typedef logic [31:0]           stat_cnt_t;

  localparam cmd_t CMD_GET   = 2'd0;
  localparam cmd_t CMD_PUT   = 2'd1;
  localparam cmd_t CMD_CLEAR = 2'd2;

  localparam logic [1:0] REG_CAPACITY = 2'd0;
  localparam cap_t       CAP_RESET    = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOCATE,
    ST_UPDATE,
    ST_RESULT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic locate;
    logic update;
    logic emit;
  } dp_ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/lkv_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lkv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                we,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                    wdata,
  input  wire logic                                re,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output      logic [WIDTH-1:0]                    rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lkv_ctrl.sv
// Sequencer for the LRU key/value cache: accept, locate, update, deliver.
// Depends on lkv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lkv_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output      logic              in_tready,
  input  wire lkv_pkg::dp_stat_t stat,
  output      lkv_pkg::dp_ctrl_t ctrl
);

  lkv_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lkv_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    in_tready = 1'b0;
    case (state_r)
      lkv_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctrl.load = 1'b1;
          state_nxt = lkv_pkg::ST_LOCATE;
        end
      end
      lkv_pkg::ST_LOCATE: begin
        ctrl.locate = 1'b1;
        state_nxt   = lkv_pkg::ST_UPDATE;
      end
      lkv_pkg::ST_UPDATE: begin
        ctrl.update = 1'b1;
        state_nxt   = lkv_pkg::ST_RESULT;
      end
      lkv_pkg::ST_RESULT: begin
        // hold until the output register can take the item
        if (stat.out_free) begin
          ctrl.emit = 1'b1;
          state_nxt = lkv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lkv_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/lkv_dp.sv
// Datapath: key registers with parallel compare, recency list, counters,
// value RAM and output register. Depends on lkv_pkg and lkv_ram.
`timescale 1ns / 1ps
`default_nettype none

module lkv_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lkv_pkg::dp_ctrl_t ctrl,
  output      lkv_pkg::dp_stat_t stat,
  input  wire logic [1:0]        in_tuser,
  input  wire logic [95:0]       in_tdata,
  input  wire lkv_pkg::cap_t     capacity,
  output      logic              out_tvalid,
  input  wire logic              out_tready,
  output      logic              out_tuser,
  output      logic [103:0]      out_tdata
);

  localparam int E = lkv_pkg::ENTRIES;

  // held item
  lkv_pkg::cmd_t   cmd_r;
  lkv_pkg::key_t   key_r;
  lkv_pkg::value_t val_r;

  // store
  lkv_pkg::key_t   keys_r [E];
  lkv_pkg::slot_t  rec_r  [E];
  lkv_pkg::cnt_t   vc_r;
  lkv_pkg::stat_cnt_t hit_cnt_r, miss_cnt_r;

  // lookup results
  logic [E-1:0]    slot_eq_r;
  logic            hit_r;
  lkv_pkg::cnt_t   hit_pos_r;
  lkv_pkg::slot_t  hit_slot_r;
  lkv_pkg::slot_t  free_slot_r;
  lkv_pkg::cnt_t   vc_ev_r;

  // result staging and output register
  logic            res_hit_r, res_get_hit_r;
  logic            out_valid_r, out_hit_r;
  logic [31:0]     out_value_r;
  lkv_pkg::cap_t   out_count_r;
  lkv_pkg::stat_cnt_t out_hits_r, out_miss_r;

  lkv_pkg::cnt_t   cap_eff;
  logic [E-1:0]    pos_hit;
  logic            any_hit;
  lkv_pkg::cnt_t   hit_pos;
  lkv_pkg::cnt_t   vc_ev;
  logic [E-1:0]    slot_used;
  lkv_pkg::slot_t  free_slot;

  logic            shift_en;
  lkv_pkg::cnt_t   shift_lim;
  lkv_pkg::slot_t  shift_head;
  logic            ram_we, ram_re;
  lkv_pkg::slot_t  ram_waddr;
  lkv_pkg::value_t ram_rdata;

  assign cap_eff = (32'(capacity) > 32'(E)) ? lkv_pkg::cnt_t'(E) : lkv_pkg::cnt_t'(capacity);

  // locate: find the matching position among valid ones, and the free slot
  // left once least-recent entries are dropped for an insert
  always_comb begin
    for (int p = 0; p < E; p++) begin
      pos_hit[p] = (lkv_pkg::cnt_t'(p) < vc_r) && slot_eq_r[rec_r[p]];
    end
    any_hit = (|pos_hit) && (cap_eff != '0);
    hit_pos = '0;
    for (int p = E - 1; p >= 0; p--) begin
      if (pos_hit[p]) begin
        hit_pos = lkv_pkg::cnt_t'(p);
      end
    end
    vc_ev = (vc_r >= cap_eff && cap_eff != '0) ? cap_eff - 1'b1 : vc_r;
    for (int s = 0; s < E; s++) begin
      slot_used[s] = 1'b0;
      for (int p = 0; p < E; p++) begin
        if ((lkv_pkg::cnt_t'(p) < vc_ev) && (rec_r[p] == lkv_pkg::slot_t'(s))) begin
          slot_used[s] = 1'b1;
        end
      end
    end
    free_slot = '0;
    for (int s = E - 1; s >= 0; s--) begin
      if (!slot_used[s]) begin
        free_slot = lkv_pkg::slot_t'(s);
      end
    end
  end

  // update: decide list shift and RAM access
  always_comb begin
    shift_en   = 1'b0;
    shift_lim  = hit_pos_r;
    shift_head = hit_slot_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = hit_slot_r;
    if (ctrl.update) begin
      case (cmd_r)
        lkv_pkg::CMD_GET: begin
          shift_en = hit_r;
          ram_re   = hit_r;
        end
        lkv_pkg::CMD_PUT: begin
          if (cap_eff != '0) begin
            shift_en = 1'b1;
            ram_we   = 1'b1;
            if (!hit_r) begin
              shift_lim  = vc_ev_r;
              shift_head = free_slot_r;
              ram_waddr  = free_slot_r;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r <= in_tuser;
      key_r <= in_tdata[63:0];
      val_r <= lkv_pkg::value_t'(in_tdata[95:64]);
      for (int s = 0; s < E; s++) begin
        slot_eq_r[s] <= (keys_r[s] == in_tdata[63:0]);
      end
    end
    if (ctrl.locate) begin
      hit_r       <= any_hit;
      hit_pos_r   <= hit_pos;
      hit_slot_r  <= rec_r[hit_pos[lkv_pkg::SLOT_W-1:0]];
      free_slot_r <= free_slot;
      vc_ev_r     <= vc_ev;
    end
    if (ctrl.update) begin
      res_hit_r     <= hit_r && (cmd_r == lkv_pkg::CMD_GET || cmd_r == lkv_pkg::CMD_PUT);
      res_get_hit_r <= hit_r && (cmd_r == lkv_pkg::CMD_GET);
      if (cmd_r == lkv_pkg::CMD_PUT && cap_eff != '0 && !hit_r) begin
        keys_r[free_slot_r] <= key_r;
      end
    end
    if (ctrl.emit) begin
      out_hit_r   <= res_hit_r;
      out_value_r <= res_get_hit_r ? 32'(ram_rdata) : 32'd0;
      out_count_r <= lkv_pkg::cap_t'(vc_r);
      out_hits_r  <= hit_cnt_r;
      out_miss_r  <= miss_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < E; p++) begin
        rec_r[p] <= '0;
      end
      vc_r        <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (shift_en) begin
        for (int p = 1; p < E; p++) begin
          if (lkv_pkg::cnt_t'(p) <= shift_lim) begin
            rec_r[p] <= rec_r[p-1];
          end
        end
        rec_r[0] <= shift_head;
      end
      if (ctrl.update) begin
        case (cmd_r)
          lkv_pkg::CMD_GET: begin
            if (hit_r) begin
              hit_cnt_r <= (&hit_cnt_r) ? hit_cnt_r : hit_cnt_r + 1'b1;
            end else begin
              miss_cnt_r <= (&miss_cnt_r) ? miss_cnt_r : miss_cnt_r + 1'b1;
            end
          end
          lkv_pkg::CMD_PUT: begin
            if (cap_eff != '0 && !hit_r) begin
              vc_r <= vc_ev_r + 1'b1;
            end
          end
          lkv_pkg::CMD_CLEAR: begin
            vc_r <= '0;
          end
          default: begin
          end
        endcase
      end
      if (ctrl.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  lkv_ram #(
    .WIDTH (lkv_pkg::VALUE_BITS),
    .DEPTH (E)
  ) u_values (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (val_r),
    .re    (ram_re),
    .raddr (hit_slot_r),
    .rdata (ram_rdata)
  );

  assign stat.out_free = !out_valid_r || out_tready;
  assign out_tvalid    = out_valid_r;
  assign out_tuser     = out_hit_r;
  assign out_tdata     = {3'b000, out_miss_r, out_hits_r, out_count_r, out_value_r};

endmodule

`default_nettype wire

FILE: rtl/lru_key_value_cache.sv
// Top level of the LRU key/value cache: APB capacity register and wiring of
// controller and datapath. Depends on lkv_pkg, lkv_ctrl, lkv_dp, lkv_ram.
`timescale 1ns / 1ps
`default_nettype none

// Fully associative least-recently-used store of 16 entries, 64-bit keys and
// 32-bit value handles. Send an item with in_tuser as the command (0 get,
// 1 put, 2 clear; 3 does nothing) and key and value in in_tdata; every item
// returns exactly one result item. Steps: an item is taken in the idle state,
// where all 16 keys are compared at once; the locate state, in the next cycle,
// finds the matching recency position and the free slot; the update state
// applies the update and starts the value RAM read; the result state loads
// the output register, waiting while that register is full and not read. The
// next item is accepted once the result state has loaded the output register;
// the registered read of the value RAM and the one-step recency update shape
// this sequence. A result waiting in the output register does not block the
// next item from starting. Capacity (APB address 0, reset 16, values above
// 16 act as 16, 0 disables the store) may be written only while no item is
// in flight. No initialization pass follows reset: stored keys and values
// need no clearing since only listed slots are ever read.
module lru_key_value_cache (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // input channel
  input  wire logic         in_tvalid,
  output      logic         in_tready,
  input  wire logic [95:0]  in_tdata,   // key [63:0], value_in [95:64]
  input  wire logic [1:0]   in_tuser,   // cmd [1:0]
  // result channel
  output      logic         out_tvalid,
  input  wire logic         out_tready,
  output      logic [103:0] out_tdata,  // value_out [31:0], entry_count [36:32],
                                        // hit_total [68:37], miss_total [100:69]
  output      logic         out_tuser,  // hit
  // configuration
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [1:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output      logic [31:0]  cfg_prdata,
  output      logic         cfg_pready
);

  lkv_pkg::cap_t     capacity_r;
  lkv_pkg::dp_ctrl_t ctrl;
  lkv_pkg::dp_stat_t stat;
  logic              cfg_wr;

  // write completes in the access phase; pready is tied high
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite
                      && (cfg_paddr == lkv_pkg::REG_CAPACITY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= lkv_pkg::CAP_RESET;
    end else if (cfg_wr) begin
      capacity_r <= cfg_pwdata[lkv_pkg::CAP_BITS-1:0];
    end
  end

  // only one register: other addresses read as zero
  assign cfg_prdata = (cfg_paddr == lkv_pkg::REG_CAPACITY)
                      ? {27'd0, capacity_r} : 32'd0;

  lkv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  lkv_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .stat       (stat),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .capacity   (capacity_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire
